// File: sv/tbpf_pkg.sv
// types and constants shared by the background pixel fetch block
`timescale 1ns / 1ps

package tbpf_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [15:0] store_address;
        logic [15:0] store_data;
    } req_beat_t;

    typedef struct packed {
        logic [31:0] argb_pixel;
        logic        is_transparent;
        logic        out_of_range;
    } rsp_beat_t;

    typedef struct packed {
        logic [2:0] index;
        logic [8:0] value;
    } cfg_beat_t;

    localparam logic [2:0] KIND_RENDER    = 3'd0;
    localparam logic [2:0] KIND_WR_MAP    = 3'd1;
    localparam logic [2:0] KIND_WR_SHEET  = 3'd2;
    localparam logic [2:0] KIND_WR_PAL    = 3'd3;
    localparam logic [2:0] KIND_WR_BITMAP = 3'd4;

    localparam logic [1:0] MODE_MAP    = 2'd0;
    localparam logic [1:0] MODE_PAL    = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    localparam logic [2:0] CFG_LAYER_MODE   = 3'd0;
    localparam logic [2:0] CFG_LAYER_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_LAYER_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_SWAP_RB      = 3'd3;
    localparam logic [2:0] CFG_BRIGHTNESS   = 3'd4;

    localparam logic [4:0] CH_FULL    = 5'h1f;
    localparam logic [4:0] CH_ZERO    = 5'h00;
    localparam logic [7:0] ALPHA_FULL = 8'hff;
    localparam logic [8:0] GAIN_FULL  = 9'd256;

endpackage

// File: sv/tbpf_if.sv
// valid/ready channel interfaces for requests, results and configuration
`timescale 1ns / 1ps

interface tbpf_req_if;
    import tbpf_pkg::*;
    logic      valid;
    logic      ready;
    req_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbpf_rsp_if;
    import tbpf_pkg::*;
    logic      valid;
    logic      ready;
    rsp_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbpf_cfg_if;
    import tbpf_pkg::*;
    logic      valid;
    logic      ready;
    cfg_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/tile_background_pixel_fetch.sv
// background layer pixel fetch: store writes and pixel lookups in one 12-stage pipeline
// throughput: one beat per cycle when not stalled, writes and renders mixed freely
// each store is read and written at a single stage, so accesses keep beat order
// an output stall freezes the whole pipeline; nothing is dropped or repeated
// reset clears valid and config registers; store contents are undefined until written
`timescale 1ns / 1ps

module tile_background_pixel_fetch
    import tbpf_pkg::*;
#(
    parameter int TILE_SIDE          = 8,
    parameter int SHEET_TILES_ACROSS = 16,
    parameter int SHEET_TILES_DOWN   = 16,
    parameter int MAP_SIDE           = 64,
    parameter int BITMAP_SIDE        = 256,
    parameter int PALETTE_ENTRIES    = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    tbpf_cfg_if.sink        cfg,
    tbpf_req_if.sink        req,
    tbpf_rsp_if.source      rsp
);

    localparam int NS          = 12;
    localparam int SHEET_W     = TILE_SIDE * SHEET_TILES_ACROSS;
    localparam int SHEET_H     = TILE_SIDE * SHEET_TILES_DOWN;
    localparam int NTILES      = SHEET_TILES_ACROSS * SHEET_TILES_DOWN;
    localparam int MAP_DEPTH   = MAP_SIDE * MAP_SIDE;
    localparam int SHEET_DEPTH = SHEET_W * SHEET_H;
    localparam int BMP_DEPTH   = BITMAP_SIDE * BITMAP_SIDE;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int SHEET_AW    = $clog2(SHEET_DEPTH);
    localparam int BMP_AW      = $clog2(BMP_DEPTH);
    localparam int PAL_AW      = $clog2(PALETTE_ENTRIES);
    localparam int TXW         = $clog2(511 / TILE_SIDE + 1);
    localparam int FW          = $clog2(TILE_SIDE);
    localparam int TLW         = (NTILES > 1) ? $clog2(NTILES) : 1;
    localparam int COLW        = (SHEET_TILES_ACROSS > 1) ? $clog2(SHEET_TILES_ACROSS) : 1;
    localparam int ROWW        = (SHEET_TILES_DOWN > 1) ? $clog2(SHEET_TILES_DOWN) : 1;
    localparam int SXW         = $clog2(SHEET_W);
    localparam int SYW         = $clog2(SHEET_H);

    // reciprocal constants for division by fixed divisors
    localparam int T_SH  = 9 + $clog2(TILE_SIDE) + 1;
    localparam int T_PW  = 9 + T_SH;
    localparam logic [T_SH-1:0] T_RC =
        T_SH'(((1 << T_SH) + TILE_SIDE - 1) / TILE_SIDE);
    localparam int NT_SH = 16 + $clog2(NTILES);
    localparam int NT_PW = 16 + NT_SH + 1;
    localparam logic [NT_SH:0] NT_RC =
        (NT_SH + 1)'(((1 << NT_SH) + NTILES - 1) / NTILES);
    localparam int A_SH  = TLW + $clog2(SHEET_TILES_ACROSS);
    localparam int A_PW  = TLW + A_SH + 1;
    localparam logic [A_SH:0] A_RC =
        (A_SH + 1)'(((1 << A_SH) + SHEET_TILES_ACROSS - 1) / SHEET_TILES_ACROSS);
    localparam int P_SH  = 8 + $clog2(PALETTE_ENTRIES);
    localparam int P_PW  = 8 + P_SH + 1;
    localparam logic [P_SH:0] P_RC =
        (P_SH + 1)'(((1 << P_SH) + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES);

    typedef struct packed {
        logic             is_render;
        logic             wr_map;
        logic             wr_sheet;
        logic             wr_pal;
        logic             wr_bmp;
        logic [15:0]      addr;
        logic [15:0]      data;
        logic [8:0]       px;
        logic [8:0]       py;
        logic [TXW-1:0]   tx;
        logic [TXW-1:0]   ty;
        logic [FW-1:0]    fx;
        logic [FW-1:0]    fy;
        logic             oor;
        logic [15:0]      mapv;
        logic [15:0]      bmp;
        logic [15:0]      tq;
        logic [TLW-1:0]   tile;
        logic [ROWW-1:0]  trow;
        logic [COLW-1:0]  tcol;
        logic [SXW-1:0]   sx;
        logic [SYW-1:0]   sy;
        logic [7:0]       pidx;
        logic [7:0]       pq;
        logic             transp;
        logic [13:0]      rp;
        logic [13:0]      gp;
        logic [13:0]      bp;
    } stg_t;

    logic [1:0]  mode_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic        swap_reg;
    logic [8:0]  bright_reg;

    stg_t           stg_reg  [NS];
    stg_t           stg_next [NS];
    logic [NS-1:0]  vld_reg;
    logic           adv;

    logic [15:0]         map_mem   [MAP_DEPTH];
    logic [7:0]          sheet_mem [SHEET_DEPTH];
    logic [15:0]         pal_mem   [PALETTE_ENTRIES];
    logic [15:0]         bmp_mem   [BMP_DEPTH];
    logic [15:0]         map_rd_reg;
    logic [7:0]          sheet_rd_reg;
    logic [15:0]         pal_rd_reg;
    logic [15:0]         bmp_rd_reg;
    logic [MAP_AW-1:0]   map_ra;
    logic [MAP_AW-1:0]   map_wa;
    logic                map_we;
    logic [BMP_AW-1:0]   bmp_ra;
    logic [BMP_AW-1:0]   bmp_wa;
    logic                bmp_we;
    logic [SHEET_AW-1:0] sheet_ra;
    logic [SHEET_AW-1:0] sheet_wa;
    logic                sheet_we;
    logic [PAL_AW-1:0]   pal_ra;
    logic [PAL_AW-1:0]   pal_wa;
    logic                pal_we;

    assign adv       = !(vld_reg[NS-1] && stg_reg[NS-1].is_render) || rsp.ready;
    assign req.ready = adv;
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MAP;
            width_reg  <= 9'd64;
            height_reg <= 9'd64;
            swap_reg   <= 1'b0;
            bright_reg <= GAIN_FULL;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_LAYER_MODE:   mode_reg   <= cfg.data.value[1:0];
                CFG_LAYER_WIDTH:  width_reg  <= cfg.data.value;
                CFG_LAYER_HEIGHT: height_reg <= cfg.data.value;
                CFG_SWAP_RB:      swap_reg   <= cfg.data.value[0];
                CFG_BRIGHTNESS:   bright_reg <= cfg.data.value;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic [T_PW-1:0]  tx_prod;
        logic [T_PW-1:0]  ty_prod;
        logic [NT_PW-1:0] tq_prod;
        logic [A_PW-1:0]  tr_prod;
        logic [P_PW-1:0]  pq_prod;
        logic             map_mode;
        logic [15:0]      c16;
        logic [4:0]       r;
        logic [4:0]       g;
        logic [4:0]       b;
        logic [8:0]       gain;
        logic [8:0]       pal_full;

        // stage 0: input capture
        stg_next[0]           = stg_reg[0];
        stg_next[0].is_render = (req.data.kind == KIND_RENDER);
        stg_next[0].wr_map    = (req.data.kind == KIND_WR_MAP);
        stg_next[0].wr_sheet  = (req.data.kind == KIND_WR_SHEET);
        stg_next[0].wr_pal    = (req.data.kind == KIND_WR_PAL);
        stg_next[0].wr_bmp    = (req.data.kind == KIND_WR_BITMAP);
        stg_next[0].addr      = req.data.store_address;
        stg_next[0].data      = req.data.store_data;
        stg_next[0].px        = req.data.pixel_x;
        stg_next[0].py        = req.data.pixel_y;

        // stage 0 -> 1: tile coordinates
        tx_prod        = T_PW'(stg_reg[0].px) * T_PW'(T_RC);
        ty_prod        = T_PW'(stg_reg[0].py) * T_PW'(T_RC);
        stg_next[1]    = stg_reg[0];
        stg_next[1].tx = tx_prod[T_SH +: TXW];
        stg_next[1].ty = ty_prod[T_SH +: TXW];

        // stage 1 -> 2: offsets in tile, range check, map and bitmap access
        map_mode       = (mode_reg == MODE_MAP);
        stg_next[2]    = stg_reg[1];
        stg_next[2].fx = FW'(stg_reg[1].px - 9'(stg_reg[1].tx) * 9'(TILE_SIDE));
        stg_next[2].fy = FW'(stg_reg[1].py - 9'(stg_reg[1].ty) * 9'(TILE_SIDE));
        if (map_mode)
        begin
            stg_next[2].oor = (10'(stg_reg[1].tx) >= 10'(width_reg))
                           || (10'(stg_reg[1].tx) >= 10'(MAP_SIDE))
                           || (10'(stg_reg[1].ty) >= 10'(height_reg))
                           || (10'(stg_reg[1].ty) >= 10'(MAP_SIDE));
        end
        else
        begin
            stg_next[2].oor = (10'(stg_reg[1].px) >= 10'(width_reg))
                           || (10'(stg_reg[1].px) >= 10'(BITMAP_SIDE))
                           || (10'(stg_reg[1].py) >= 10'(height_reg))
                           || (10'(stg_reg[1].py) >= 10'(BITMAP_SIDE));
        end
        map_ra = MAP_AW'(stg_reg[1].ty) * MAP_AW'(MAP_SIDE) + MAP_AW'(stg_reg[1].tx);
        map_wa = MAP_AW'(stg_reg[1].addr);
        map_we = vld_reg[1] && stg_reg[1].wr_map
              && (32'(stg_reg[1].addr) < 32'(MAP_DEPTH));
        bmp_ra = BMP_AW'(stg_reg[1].py) * BMP_AW'(BITMAP_SIDE) + BMP_AW'(stg_reg[1].px);
        bmp_wa = BMP_AW'(stg_reg[1].addr);
        bmp_we = vld_reg[1] && stg_reg[1].wr_bmp
              && (32'(stg_reg[1].addr) < 32'(BMP_DEPTH));

        // stage 2 -> 3: map entry quotient by tile count
        tq_prod          = NT_PW'(map_rd_reg) * NT_PW'(NT_RC);
        stg_next[3]      = stg_reg[2];
        stg_next[3].mapv = map_rd_reg;
        stg_next[3].bmp  = bmp_rd_reg;
        stg_next[3].tq   = tq_prod[NT_SH +: 16];

        // stage 3 -> 4: tile index wrapped to the sheet
        stg_next[4]      = stg_reg[3];
        stg_next[4].tile = TLW'(stg_reg[3].mapv - stg_reg[3].tq * 16'(NTILES));

        // stage 4 -> 5: tile row in the sheet
        tr_prod          = A_PW'(stg_reg[4].tile) * A_PW'(A_RC);
        stg_next[5]      = stg_reg[4];
        stg_next[5].trow = tr_prod[A_SH +: ROWW];

        // stage 5 -> 6: tile column in the sheet
        stg_next[6]      = stg_reg[5];
        stg_next[6].tcol = COLW'(13'(stg_reg[5].tile)
                         - 13'(stg_reg[5].trow) * 13'(SHEET_TILES_ACROSS));

        // stage 6 -> 7: sheet pixel coordinates
        stg_next[7]    = stg_reg[6];
        stg_next[7].sx = SXW'((SXW + 1)'(stg_reg[6].tcol) * (SXW + 1)'(TILE_SIDE)
                       + (SXW + 1)'(stg_reg[6].fx));
        stg_next[7].sy = SYW'((SYW + 1)'(stg_reg[6].trow) * (SYW + 1)'(TILE_SIDE)
                       + (SYW + 1)'(stg_reg[6].fy));

        // stage 7 -> 8: sheet access
        sheet_ra = SHEET_AW'(stg_reg[7].sy) * SHEET_AW'(SHEET_W) + SHEET_AW'(stg_reg[7].sx);
        sheet_wa = SHEET_AW'(stg_reg[7].addr);
        sheet_we = vld_reg[7] && stg_reg[7].wr_sheet
                && (32'(stg_reg[7].addr) < 32'(SHEET_DEPTH));
        stg_next[8] = stg_reg[7];

        // stage 8 -> 9: palette index quotient
        stg_next[9]      = stg_reg[8];
        stg_next[9].pidx = map_mode ? sheet_rd_reg : stg_reg[8].bmp[7:0];
        pq_prod          = P_PW'(stg_next[9].pidx) * P_PW'(P_RC);
        stg_next[9].pq   = pq_prod[P_SH +: 8];

        // stage 9 -> 10: palette access
        pal_full = 9'(stg_reg[9].pidx) - 9'(stg_reg[9].pq) * 9'(PALETTE_ENTRIES);
        pal_ra   = PAL_AW'(pal_full);
        pal_wa   = PAL_AW'(stg_reg[9].addr);
        pal_we   = vld_reg[9] && stg_reg[9].wr_pal
                && (32'(stg_reg[9].addr) < 32'(PALETTE_ENTRIES));
        stg_next[10] = stg_reg[9];

        // stage 10 -> 11: color key and brightness
        c16  = (map_mode || mode_reg == MODE_PAL) ? pal_rd_reg : stg_reg[10].bmp;
        gain = (bright_reg > GAIN_FULL) ? GAIN_FULL : bright_reg;
        r    = swap_reg ? c16[4:0] : c16[14:10];
        g    = c16[9:5];
        b    = swap_reg ? c16[14:10] : c16[4:0];
        stg_next[11]        = stg_reg[10];
        stg_next[11].transp = c16[15]
                           || (c16[14:10] == CH_FULL && c16[9:5] == CH_ZERO
                               && c16[4:0] == CH_FULL);
        stg_next[11].rp     = 14'(r) * 14'(gain);
        stg_next[11].gp     = 14'(g) * 14'(gain);
        stg_next[11].bp     = 14'(b) * 14'(gain);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg <= stg_next;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (map_we)
            begin
                map_mem[map_wa] <= stg_reg[1].data;
            end
            map_rd_reg <= map_mem[map_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (bmp_we)
            begin
                bmp_mem[bmp_wa] <= stg_reg[1].data;
            end
            bmp_rd_reg <= bmp_mem[bmp_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sheet_we)
            begin
                sheet_mem[sheet_wa] <= stg_reg[7].data[7:0];
            end
            sheet_rd_reg <= sheet_mem[sheet_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pal_we)
            begin
                pal_mem[pal_wa] <= stg_reg[9].data;
            end
            pal_rd_reg <= pal_mem[pal_ra];
        end
    end

    // result beat
    assign rsp.valid = vld_reg[NS-1] && stg_reg[NS-1].is_render;
    assign rsp.data.out_of_range   = stg_reg[NS-1].oor;
    assign rsp.data.is_transparent = !stg_reg[NS-1].oor && stg_reg[NS-1].transp;
    assign rsp.data.argb_pixel     = (stg_reg[NS-1].oor || stg_reg[NS-1].transp) ? 32'd0 :
        {ALPHA_FULL,
         stg_reg[NS-1].rp[12:8], 3'b000,
         stg_reg[NS-1].gp[12:8], 3'b000,
         stg_reg[NS-1].bp[12:8], 3'b000};

    // checks
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> vld_reg == $past(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.is_transparent && rsp.data.out_of_range))
        else $error("transparent and out of range both set");

    a_zero_when_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.data.is_transparent || rsp.data.out_of_range)
        |-> rsp.data.argb_pixel == 32'd0)
        else $error("flagged beat carries a nonzero pixel");

    a_opaque_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.is_transparent && !rsp.data.out_of_range
        |-> rsp.data.argb_pixel[31:24] == ALPHA_FULL)
        else $error("opaque beat without full alpha");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("input held off with no result waiting");

endmodule
